// ===== src/nwt_pkg.sv =====
package nwt_pkg;

  localparam int MAX_WAYPOINTS = 1024;
  localparam int ADDR_W        = $clog2(MAX_WAYPOINTS);
  localparam int CNT_W         = $clog2(MAX_WAYPOINTS + 1);
  localparam int COORD_W       = 24;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int ID_W          = 16;
  localparam int PREV_W        = ID_W + 1;
  localparam int WSPAN_W       = PREV_W + 1;
  localparam int DIST_W        = 50;
  localparam int WIN_W         = 4;
  localparam int KIND_W        = 2;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(5);

  typedef enum logic [KIND_W-1:0] {
    KIND_START = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQX,
    ST_SQY,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } word_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    word_t             wdata;
  } mem_req_t;

  typedef struct packed {
    logic prod_en;
    logic sel_y;
    logic acc_en;
  } dist_ctl_t;

endpackage

// ===== src/nwt_table.sv =====
module nwt_table (
  input  logic             clk,
  input  nwt_pkg::mem_req_t req,
  output nwt_pkg::word_t   rdata
);
  import nwt_pkg::*;

  word_t mem [MAX_WAYPOINTS];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/nwt_dist_unit.sv =====
module nwt_dist_unit (
  input  logic                              clk,
  input  nwt_pkg::dist_ctl_t                ctl,
  input  logic signed [nwt_pkg::COORD_W-1:0] px,
  input  logic signed [nwt_pkg::COORD_W-1:0] py,
  input  nwt_pkg::word_t                    entry,
  output logic [nwt_pkg::DIST_W-1:0]        sum
);
  import nwt_pkg::*;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic [2*DIFF_W-1:0]      sq;
  logic [DIST_W-1:0]        prod_r;
  logic [DIST_W-1:0]        acc_r;

  // one squarer shared by the x and y terms
  always_comb begin
    if (ctl.sel_y) begin
      diff = DIFF_W'(py) - DIFF_W'(entry.y);
    end else begin
      diff = DIFF_W'(px) - DIFF_W'(entry.x);
    end
    mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    sq  = mag * mag;
  end

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod_r <= DIST_W'(sq);
    end
    if (ctl.acc_en) begin
      acc_r <= prod_r;
    end
  end

  assign sum = acc_r + prod_r;

endmodule

// ===== src/nwt_ctrl.sv =====
module nwt_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [nwt_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [nwt_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [nwt_pkg::COORD_W-1:0] in_coord_y,
  input  logic [nwt_pkg::ID_W-1:0]           in_point_id,
  input  logic [nwt_pkg::WIN_W-1:0]          window_half,
  output nwt_pkg::mem_req_t                  mem_req,
  input  nwt_pkg::word_t                     mem_rdata,
  output nwt_pkg::dist_ctl_t                 dctl,
  output logic signed [nwt_pkg::COORD_W-1:0] px,
  output logic signed [nwt_pkg::COORD_W-1:0] py,
  input  logic [nwt_pkg::DIST_W-1:0]         sum,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic [nwt_pkg::ID_W-1:0]           out_nearest_id,
  output logic [nwt_pkg::DIST_W-1:0]         out_dist_sq
);
  import nwt_pkg::*;

  state_t                    state_r;
  state_t                    state_nxt;
  logic [CNT_W-1:0]          count_r;
  logic                      scanned_r;
  logic signed [PREV_W-1:0]  prev_r;
  logic [ADDR_W-1:0]         idx_r;
  logic [ADDR_W-1:0]         hi_r;
  logic signed [COORD_W-1:0] px_r;
  logic signed [COORD_W-1:0] py_r;
  logic                      found_r;
  logic [ID_W-1:0]           best_id_r;
  logic [DIST_W-1:0]         best_d_r;
  logic                      out_valid_r;
  logic                      out_found_r;
  logic [ID_W-1:0]           out_id_r;
  logic [DIST_W-1:0]         out_dist_r;

  logic                      full;
  logic                      out_free;
  logic                      last;
  logic                      better;
  logic signed [WSPAN_W-1:0] lo_s;
  logic signed [WSPAN_W-1:0] hi_s;
  logic signed [WSPAN_W-1:0] top_s;
  logic signed [WSPAN_W-1:0] lo_c;
  logic signed [WSPAN_W-1:0] hi_c;
  logic                      empty;

  assign full     = (count_r >= CNT_W'(MAX_WAYPOINTS));
  assign out_free = !out_valid_r || out_ready;
  assign last     = (idx_r == hi_r);
  assign better   = !found_r || (sum < best_d_r);

  // search window from the previous nearest id; the whole table until the first query after start or reset
  always_comb begin
    lo_s  = {prev_r[PREV_W-1], prev_r} - WSPAN_W'(window_half);
    hi_s  = {prev_r[PREV_W-1], prev_r} + WSPAN_W'(window_half);
    top_s = WSPAN_W'(count_r) - WSPAN_W'(1);
    if (!scanned_r) begin
      lo_c = '0;
      hi_c = top_s;
    end else begin
      lo_c = (lo_s < 0) ? WSPAN_W'(0) : lo_s;
      hi_c = (hi_s > top_s) ? top_s : hi_s;
    end
    empty = (hi_c < lo_c);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_kind == KIND_QUERY) begin
          state_nxt = empty ? ST_DONE : ST_READ;
        end
      end
      ST_READ: state_nxt = ST_SQX;
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = last ? ST_DONE : ST_SQX;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    mem_req.wr_en = in_ready && in_valid && (in_kind == KIND_LOAD) && !full;
    mem_req.rd_en = (state_r == ST_READ) || (state_r == ST_ACC && !last);
    case (state_r)
      ST_IDLE: mem_req.addr = count_r[ADDR_W-1:0];
      ST_ACC:  mem_req.addr = idx_r + ADDR_W'(1);
      default: mem_req.addr = idx_r;
    endcase
    mem_req.wdata = '{id: in_point_id, y: in_coord_y, x: in_coord_x};
    dctl.prod_en  = (state_r == ST_SQX) || (state_r == ST_SQY);
    dctl.sel_y    = (state_r == ST_SQY);
    dctl.acc_en   = (state_r == ST_SQY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scanned_r   <= 1'b0;
      prev_r      <= '1;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            case (in_kind)
              KIND_START: begin
                count_r   <= '0;
                scanned_r <= 1'b0;
                prev_r    <= '1;
              end
              KIND_LOAD: begin
                if (!full) begin
                  count_r <= count_r + CNT_W'(1);
                end
              end
              KIND_QUERY: begin
                px_r      <= in_coord_x;
                py_r      <= in_coord_y;
                scanned_r <= 1'b1;
                idx_r     <= lo_c[ADDR_W-1:0];
                hi_r      <= hi_c[ADDR_W-1:0];
                found_r   <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_ACC: begin
          if (better) begin
            found_r   <= 1'b1;
            best_d_r  <= sum;
            best_id_r <= mem_rdata.id;
          end
          if (!last) begin
            idx_r <= idx_r + ADDR_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_found_r <= found_r;
            out_id_r    <= found_r ? best_id_r : '0;
            out_dist_r  <= found_r ? best_d_r : '0;
            prev_r      <= found_r ? {1'b0, best_id_r} : '1;
          end
        end
        default: ;
      endcase
    end
  end

  assign px             = px_r;
  assign py             = py_r;
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_nearest_id = out_id_r;
  assign out_dist_sq    = out_dist_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_WAYPOINTS))
    else $error("entry count beyond table size");

  a_read_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.rd_en |-> (CNT_W'(mem_req.addr) < count_r))
    else $error("read of an entry past the fill count");

  a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |-> (idx_r <= hi_r))
    else $error("scan index past window end");

  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished search did not post a word");

  a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free && found_r) |=>
      (prev_r == {1'b0, $past(best_id_r)}))
    else $error("previous nearest not updated from result");
`endif

endmodule

// ===== src/nearest_waypoint_tracker.sv =====
// channel  direction  word
// in_      input      kind, coord_x, coord_y, point_id
// out_     output     found, nearest_id, dist_sq (pose queries only)
// cfg_     input      window_half, always ready
//
// start, load and unused kinds are taken in the idle state and may follow back to back
// a pose query holds in_ready low: read, x square, y square, accumulate per entry, done
// an empty window goes straight to done; the single 25x25 squarer serves x and y terms
// the table holds up to 1024 entries; reset clears count and history, sets window to 5
// a query ending while the last result still waits on out_ready holds in its done
// state until that word is taken
module nearest_waypoint_tracker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [nwt_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [nwt_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [nwt_pkg::COORD_W-1:0] in_coord_y,
  input  logic [nwt_pkg::ID_W-1:0]           in_point_id,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic [nwt_pkg::ID_W-1:0]           out_nearest_id,
  output logic [nwt_pkg::DIST_W-1:0]         out_dist_sq,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nwt_pkg::WIN_W-1:0]          cfg_window_half
);
  import nwt_pkg::*;

  logic [WIN_W-1:0]          window_half_r;
  mem_req_t                  mem_req;
  word_t                     mem_rdata;
  dist_ctl_t                 dctl;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic [DIST_W-1:0]         sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_half_r <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_half_r <= cfg_window_half;
    end
  end

  nwt_table u_table (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  nwt_dist_unit u_dist (
    .clk   (clk),
    .ctl   (dctl),
    .px    (px),
    .py    (py),
    .entry (mem_rdata),
    .sum   (sum)
  );

  nwt_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_point_id    (in_point_id),
    .window_half    (window_half_r),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata),
    .dctl           (dctl),
    .px             (px),
    .py             (py),
    .sum            (sum),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_nearest_id (out_nearest_id),
    .out_dist_sq    (out_dist_sq)
  );

endmodule
